@@ rtl/pssv_pkg.sv @@
// ============================================================================
// pssv_pkg: plucked string voice shared definitions
// Widths, register indexes, microcode format and program, saturation helpers.
// ============================================================================
package pssv_pkg;

    localparam int MAX_DELAY_DEF = 4096;
    localparam int FRAC_BITS_DEF = 8;

    localparam int SAMPLE_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int LEN_W       = 13;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_GAIN    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWPASS_COEFF = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALLPASS_COEFF = 2'd3;

    // reset values
    localparam logic [LEN_W-1:0]    DELAY_LENGTH_RST  = 13'd100;
    localparam logic [15:0]         DECAY_GAIN_RST    = 16'd65208;
    localparam logic [15:0]         LOWPASS_COEFF_RST = 16'd32768;
    localparam logic signed [15:0]  ALLPASS_COEFF_RST = 16'sd0;

    // microcode
    typedef logic [3:0] step_t;

    localparam step_t STEP_ACCEPT    = 4'd0;
    localparam step_t STEP_READ      = 4'd1;
    localparam step_t STEP_MUL_DECAY = 4'd2;
    localparam step_t STEP_SUM       = 4'd3;
    localparam step_t STEP_MUL_LP    = 4'd4;
    localparam step_t STEP_LP        = 4'd5;
    localparam step_t STEP_MUL_AP    = 4'd6;
    localparam step_t STEP_AP        = 4'd7;
    localparam step_t STEP_COMMIT    = 4'd8;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NO_IN,
        JC_OUT_BUSY
    } jmp_cond_t;

    typedef enum logic [1:0] {
        MS_NONE,
        MS_DECAY,
        MS_LOWPASS,
        MS_ALLPASS
    } mul_sel_t;

    typedef enum logic [1:0] {
        PS_NONE,
        PS_S,
        PS_LP,
        PS_Y
    } post_sel_t;

    typedef struct packed {
        jmp_cond_t jc;
        step_t     target;
        logic      take_in;
        mul_sel_t  mul;
        post_sel_t post;
        logic      mem_rd;
        logic      commit;
        logic      last;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        jc: JC_NONE, target: STEP_ACCEPT, take_in: 1'b0, mul: MS_NONE,
        post: PS_NONE, mem_rd: 1'b0, commit: 1'b0, last: 1'b0
    };

    // control store: one word per step
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c = CTRL_NOP;
        case (step)
            STEP_ACCEPT:
            begin
                c.jc      = JC_NO_IN;
                c.target  = STEP_ACCEPT;
                c.take_in = 1'b1;
            end
            STEP_READ:      c.mem_rd = 1'b1;
            STEP_MUL_DECAY: c.mul    = MS_DECAY;
            STEP_SUM:       c.post   = PS_S;
            STEP_MUL_LP:    c.mul    = MS_LOWPASS;
            STEP_LP:        c.post   = PS_LP;
            STEP_MUL_AP:    c.mul    = MS_ALLPASS;
            STEP_AP:        c.post   = PS_Y;
            STEP_COMMIT:
            begin
                c.jc     = JC_OUT_BUSY;
                c.target = STEP_COMMIT;
                c.commit = 1'b1;
                c.last   = 1'b1;
            end
            default:        c.last   = 1'b1;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
        logic signed [15:0] r;
        if (v > 33'sd32767)
            r = 16'sh7FFF;
        else if (v < -33'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

@@ rtl/pssv_if.sv @@
// ============================================================================
// pssv_in_if / pssv_out_if: voice request and result channels
// Valid/ready channels carrying one excitation request or one output sample.
// ============================================================================
interface pssv_in_if
    import pssv_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       new_note;
    logic signed [SAMPLE_W-1:0] excitation;

    modport source (output valid, output new_note, output excitation, input ready);
    modport sink   (input valid, input new_note, input excitation, output ready);
endinterface

interface pssv_out_if
    import pssv_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/pssv_ram.sv @@
// ============================================================================
// pssv_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module pssv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/plucked_string_synth_voice.sv @@
// ============================================================================
// plucked_string_synth_voice: Karplus-Strong string with allpass tuning
// Microcoded sequencer over one shared 34x17 multiplier and a post unit.
// ============================================================================
// The 9-step microprogram (accept, read, decay product, sum, lowpass product,
//   lowpass, allpass product, allpass, commit) runs the three products
//   through the single shared multiplier. A new request is taken only at
//   accept; a pending result stalls the program at its commit step only.
// Reset: asynchronous, active low; clears config to defaults, filter states,
//   write pointer and fill count. The delay RAM is not cleared; the fill
//   count keeps unwritten entries from ever being used.
module plucked_string_synth_voice
    import pssv_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pssv_in_if.sink                in_ch,
    pssv_out_if.source             out_ch
);

    localparam int AW = $clog2(MAX_DELAY);      // delay RAM address
    localparam int FW = $clog2(MAX_DELAY + 1);  // fill count / length

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]   delay_length_reg;
    logic [15:0]        decay_gain_reg;
    logic [15:0]        lowpass_coeff_reg;
    logic signed [15:0] allpass_coeff_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg  <= DELAY_LENGTH_RST;
            decay_gain_reg    <= DECAY_GAIN_RST;
            lowpass_coeff_reg <= LOWPASS_COEFF_RST;
            allpass_coeff_reg <= ALLPASS_COEFF_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[LEN_W-1:0];
                REG_DECAY_GAIN:    decay_gain_reg    <= cfg_data;
                REG_LOWPASS_COEFF: lowpass_coeff_reg <= cfg_data;
                REG_ALLPASS_COEFF: allpass_coeff_reg <= $signed(cfg_data);
                default:           ;
            endcase
        end
    end

    // Effective length: zero acts as one, clamp to the line size
    logic [31:0]   len_wide;
    logic [FW-1:0] len_eff;

    always_comb
    begin
        len_wide = 32'(delay_length_reg);
        if (len_wide == 32'd0)
            len_wide = 32'd1;
        else if (len_wide > 32'(MAX_DELAY))
            len_wide = 32'(MAX_DELAY);
        len_eff = len_wide[FW-1:0];
    end

    // ------------------------------------------------------------------
    // Sequencer: step counter, control store, conditional jumps
    // ------------------------------------------------------------------
    step_t step_reg, step_next;
    ctrl_t ctrl;
    logic  cond_hit;
    logic  go;            // step's action takes effect this cycle
    logic  out_valid_reg, out_valid_next;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        case (ctrl.jc)
            JC_NO_IN:    cond_hit = !in_ch.valid;
            JC_OUT_BUSY: cond_hit = out_valid_reg && !out_ch.ready;
            default:     cond_hit = 1'b0;
        endcase
    end

    assign go = !cond_hit;

    // next step
    always_comb
    begin
        if (cond_hit)
            step_next = ctrl.target;
        else if (ctrl.last)
            step_next = STEP_ACCEPT;
        else
            step_next = step_t'(step_reg + step_t'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_ACCEPT;
        else
            step_reg <= step_next;
    end

    // decoded strobes
    logic accept;
    logic commit;
    logic in_ready;

    always_comb
    begin
        in_ready = ctrl.take_in;
        accept   = ctrl.take_in && in_ch.valid;
        commit   = ctrl.commit && go;
    end

    assign in_ch.ready = in_ready;

    // ------------------------------------------------------------------
    // Delay line bookkeeping
    // ------------------------------------------------------------------
    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          v_zero_reg;
    logic [FW:0]   rd_sum;
    logic [FW:0]   rd_wrap;
    logic [31:0]   ram_rdata;

    always_comb
    begin
        rd_sum = (FW+1)'(wp_reg) + (FW+1)'(MAX_DELAY) - (FW+1)'(len_eff);
        if (rd_sum >= (FW+1)'(MAX_DELAY))
            rd_wrap = rd_sum - (FW+1)'(MAX_DELAY);
        else
            rd_wrap = rd_sum;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_addr_reg <= rd_wrap[AW-1:0];
            // restart empties the line for this request
            v_zero_reg  <= in_ch.new_note || (fill_reg < len_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept && in_ch.new_note)
            fill_reg <= '0;
        else if (commit)
        begin
            wp_reg <= (wp_reg == AW'(MAX_DELAY - 1)) ? '0 : AW'(wp_reg + AW'(1));
            if (fill_reg != FW'(MAX_DELAY))
                fill_reg <= FW'(fill_reg + FW'(1));
        end
    end

    // ------------------------------------------------------------------
    // Datapath: shared multiplier, then truncate/add/saturate post unit
    // ------------------------------------------------------------------
    logic signed [15:0] exc_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] lp_reg;
    logic signed [31:0] lp_prev_reg;
    logic signed [31:0] ap_in_reg;
    logic signed [31:0] ap_out_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
            exc_reg <= in_ch.excitation;
    end

    logic signed [33:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [31:0] v_sample;

    assign v_sample = v_zero_reg ? 32'sd0 : $signed(ram_rdata);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul)
            MS_DECAY:
            begin
                mul_a = 34'(v_sample);
                mul_b = $signed({1'b0, decay_gain_reg});
            end
            MS_LOWPASS:
            begin
                mul_a = 34'(s_reg) + 34'(lp_prev_reg);
                mul_b = $signed({1'b0, lowpass_coeff_reg});
            end
            MS_ALLPASS:
            begin
                mul_a = 34'(lp_reg) - 34'(ap_out_reg);
                mul_b = 17'(allpass_coeff_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul != MS_NONE)
            prod_reg <= mul_a * mul_b;
    end

    // truncation toward zero: bias negatives before the arithmetic shift
    logic signed [50:0] prod_b16, prod_b15;
    logic signed [35:0] tr_sel;
    logic signed [39:0] addend;
    logic signed [39:0] post_sum;
    logic signed [31:0] post_res;

    always_comb
    begin
        prod_b16 = prod_reg + (prod_reg[50] ? 51'sd65535 : 51'sd0);
        prod_b15 = prod_reg + (prod_reg[50] ? 51'sd32767 : 51'sd0);
        if (ctrl.post == PS_Y)
            tr_sel = 36'(prod_b15 >>> 15);
        else
            tr_sel = 36'(prod_b16 >>> 16);
        case (ctrl.post)
            PS_S:    addend = 40'(exc_reg) <<< FRAC_BITS;
            PS_Y:    addend = 40'(ap_in_reg);
            default: addend = '0;
        endcase
        post_sum = 40'(tr_sel) + addend;
        post_res = sat32(post_sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.post == PS_S)
            s_reg <= post_res;
        if (ctrl.post == PS_LP)
            lp_reg <= post_res;
    end

    // filter states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_prev_reg <= '0;
            ap_in_reg   <= '0;
            ap_out_reg  <= '0;
        end
        else if (accept && in_ch.new_note)
        begin
            lp_prev_reg <= '0;
            ap_in_reg   <= '0;
            ap_out_reg  <= '0;
        end
        else
        begin
            if (ctrl.post == PS_LP)
                lp_prev_reg <= s_reg;
            if (ctrl.post == PS_Y)
            begin
                ap_in_reg  <= lp_reg;
                ap_out_reg <= post_res;
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay RAM
    // ------------------------------------------------------------------
    pssv_ram #(
        .WIDTH (32),
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_delay (
        .clk   (clk),
        .we    (commit),
        .waddr (wp_reg),
        .wdata (ap_out_reg),
        .re    (ctrl.mem_rd),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Output register: y / 2^FRAC_BITS toward zero, saturate to 16 bits
    // ------------------------------------------------------------------
    logic signed [32:0]         y_biased;
    logic signed [SAMPLE_W-1:0] sample_reg;

    always_comb
    begin
        y_biased = 33'(ap_out_reg)
                 + (ap_out_reg[31] ? ((33'sd1 <<< FRAC_BITS) - 33'sd1) : 33'sd0);
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            sample_reg <= sat16(y_biased >>> FRAC_BITS);
    end

    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_reg;

endmodule

@@ rtl/pssv_checker.sv @@
// ============================================================================
// pssv_assertions: port-level checks for the plucked string voice
// Tracks requests in flight and checks result ordering against them.
// ============================================================================
module pssv_assertions
    import pssv_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] sample_out
);

    logic       in_acc, out_acc;
    logic [1:0] cnt_reg, cnt_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !out_acc)
            cnt_next = cnt_reg + 2'd1;
        else if (!in_acc && out_acc)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // a result never shows without an open request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cnt_reg != 2'd0))
        else $error("result without request");

    // at most one request in work plus one result waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ready)
        else $error("request taken with two in flight");

    // a request is not done at once: no result and no new request right after taking one into an empty block
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cnt_reg == 2'd0) |=> (!in_ready && !out_valid))
        else $error("result or request too early");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result changed");

endmodule

bind plucked_string_synth_voice pssv_assertions u_pssv_assertions (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .sample_out (out_ch.sample_out)
);
